// ----- src/pll_pkg.sv -----
package pll_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 7;
  // Wide enough to hold any position or any count without wrapping.
  localparam int EPOS_W  = 7;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_READ_OUT  = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // A link that points outside the pool is taken as slot zero.
  function automatic slot_t slot_ok(slot_t s);
    return (32'(s) < 32'(CAPACITY)) ? s : '0;
  endfunction

  function automatic data_t to_store(logic signed [VALUE_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic signed [VALUE_W-1:0] to_element(data_t d);
    return VALUE_W'(signed'(d));
  endfunction

endpackage

// ----- src/pll_req_if.sv -----
interface pll_req_if
  import pll_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

// ----- src/pll_res_if.sv -----
interface pll_res_if
  import pll_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STAT_W-1:0]          status;
  logic [POS_W-1:0]           where;
  logic signed [VALUE_W-1:0]  element;
  logic [OCNT_W-1:0]          count;
  logic                       last;

  modport source (output valid, status, where, element, count, last, input ready);
  modport sink   (input valid, status, where, element, count, last, output ready);
endinterface

// ----- src/pll_ram.sv -----
module pll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/positional_linked_list_engine.sv -----
// Insert or delete at the front, and any refused request: decided in DECIDE, result loaded from EMIT.
// Insert or delete at position p >= 1 (back included): WALK follows one link per cycle, then INS2/DEL2, EMIT.
// Read-out of n elements: after DECIDE, READ gives one result per cycle while the output register is free.
// Sequential: one request at a time; the next is taken once the result sits in the output register.
// Reset is asynchronous, active low; it empties the list. The node memories are not cleared.
module positional_linked_list_engine
  import pll_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pll_req_if.sink           req_i,
  pll_res_if.source         res_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_INS2   = 3'd3;
  localparam logic [2:0] ST_DEL2   = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  // List descriptor, all reset.
  slot_t               first_q, first_d;
  slot_t               final_q, final_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [CNT_W-1:0]    count_q, count_d;

  // Request and walk registers, no reset needed.
  logic [FUNC_W-1:0]         func_q, func_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [EPOS_W-1:0]         ep_q, ep_d;
  slot_t                     cur_q, cur_d;
  slot_t                     prev_q, prev_d;
  slot_t                     dead_q, dead_d;
  slot_t                     rem_q, rem_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [STAT_W-1:0]         st_q, st_d;
  logic [POS_W-1:0]          wh_q, wh_d;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic [STAT_W-1:0]         out_status_q, out_status_d;
  logic [POS_W-1:0]          out_where_q, out_where_d;
  logic signed [VALUE_W-1:0] out_element_q, out_element_d;
  logic [OCNT_W-1:0]         out_count_q, out_count_d;
  logic                      out_last_q, out_last_d;
  logic                      out_free;
  logic                      out_load;

  // Memory ports. Both memories share one read address.
  slot_t raddr;
  logic  lwe, vwe;
  slot_t lwaddr;
  slot_t lwdata;
  slot_t lrdata;
  data_t vrdata;

  // Lowest free slot of the pool.
  slot_t free_slot;
  logic  free_found;

  logic [EPOS_W-1:0] cnt_ext;
  logic [EPOS_W-1:0] ep;
  logic              is_insert;

  pll_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (raddr),
    .rdata_o (lrdata)
  );

  pll_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (free_slot),
    .wdata_i (to_store(value_q)),
    .raddr_i (raddr),
    .rdata_o (vrdata)
  );

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign cnt_ext   = EPOS_W'(count_q);
  assign is_insert = (func_q == FUNC_INS_FRONT) || (func_q == FUNC_INS_BACK) ||
                     (func_q == FUNC_INS_AT);
  assign out_free  = !out_valid_q || res_o.ready;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.status  = out_status_q;
  assign res_o.where   = out_where_q;
  assign res_o.element = out_element_q;
  assign res_o.count   = out_count_q;
  assign res_o.last    = out_last_q;

  // Position that the request acts on, resolved from the current count.
  always_comb begin
    unique case (func_q)
      FUNC_INS_BACK: ep = cnt_ext;
      FUNC_INS_AT,
      FUNC_DEL_AT:   ep = EPOS_W'(pos_q);
      FUNC_DEL_BACK: ep = (count_q == '0) ? '0 : cnt_ext - EPOS_W'(1);
      default:       ep = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    final_d  = final_q;
    used_d   = used_q;
    count_d  = count_q;
    func_d   = func_q;
    value_d  = value_q;
    pos_d    = pos_q;
    ep_d     = ep_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    dead_d   = dead_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    st_d     = st_q;
    wh_d     = wh_q;
    out_load = 1'b0;
    out_status_d  = out_status_q;
    out_where_d   = out_where_q;
    out_element_d = out_element_q;
    out_count_d   = out_count_q;
    out_last_d    = out_last_q;
    // By default the memories look at the head, so that the head's link is
    // ready in the cycle after a request is accepted.
    raddr  = first_q;
    lwe    = 1'b0;
    lwaddr = free_slot;
    lwdata = first_q;
    vwe    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          value_d = req_i.value;
          pos_d   = req_i.position;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        ep_d  = ep;
        cur_d = first_q;
        rem_d = SLOT_W'(ep - EPOS_W'(1));
        idx_d = '0;
        st_d  = STAT_OK;
        wh_d  = POS_W'(ep);
        if (is_insert) begin
          // A bad position is reported before a full pool.
          if (ep > cnt_ext) begin
            st_d    = STAT_BAD;
            wh_d    = '0;
            state_d = ST_EMIT;
          end else if (!free_found || cnt_ext >= EPOS_W'(CAPACITY)) begin
            st_d    = STAT_FULL;
            wh_d    = '0;
            state_d = ST_EMIT;
          end else begin
            vwe = 1'b1;
            if (ep == '0) begin
              // New head: its link is the old head.
              lwe     = 1'b1;
              first_d = free_slot;
              if (count_q == '0) begin
                final_d = free_slot;
              end
              used_d[free_slot] = 1'b1;
              count_d = count_q + CNT_W'(1);
              state_d = ST_EMIT;
            end else begin
              state_d = ST_WALK;
            end
          end
        end else if (func_q == FUNC_DEL_FRONT || func_q == FUNC_DEL_BACK ||
                     func_q == FUNC_DEL_AT) begin
          if (ep >= cnt_ext) begin
            st_d    = STAT_BAD;
            wh_d    = '0;
            state_d = ST_EMIT;
          end else if (ep == '0) begin
            // The head's link was read while the request was accepted.
            used_d[first_q] = 1'b0;
            count_d = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              first_d = '0;
              final_d = '0;
            end else begin
              first_d = slot_ok(lrdata);
            end
            state_d = ST_EMIT;
          end else begin
            state_d = ST_WALK;
          end
        end else if (func_q == FUNC_READ_OUT) begin
          if (count_q == '0) begin
            st_d    = STAT_BAD;
            wh_d    = '0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          // Unused request code: no result and no change.
          state_d = ST_IDLE;
        end
      end

      ST_WALK: begin
        // The link of cur_q arrives now; follow it until the node in front
        // of the target position is reached.
        if (rem_q != '0) begin
          cur_d = slot_ok(lrdata);
          rem_d = rem_q - SLOT_W'(1);
          raddr = slot_ok(lrdata);
        end else begin
          prev_d = cur_q;
          if (is_insert) begin
            // New node takes over the link of its predecessor.
            lwe     = 1'b1;
            lwaddr  = free_slot;
            lwdata  = lrdata;
            state_d = ST_INS2;
          end else begin
            // Fetch the link of the node being removed.
            raddr   = slot_ok(lrdata);
            dead_d  = slot_ok(lrdata);
            state_d = ST_DEL2;
          end
        end
      end

      ST_INS2: begin
        lwe    = 1'b1;
        lwaddr = prev_q;
        lwdata = free_slot;
        if (ep_q == cnt_ext) begin
          final_d = free_slot;
        end
        used_d[free_slot] = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = ST_EMIT;
      end

      ST_DEL2: begin
        lwe    = 1'b1;
        lwaddr = prev_q;
        lwdata = lrdata;
        if (ep_q == cnt_ext - EPOS_W'(1)) begin
          final_d = prev_q;
        end
        used_d[dead_q] = 1'b0;
        count_d = count_q - CNT_W'(1);
        state_d = ST_EMIT;
      end

      ST_READ: begin
        // Value and link of cur_q are on the memory outputs. Hold the read
        // address while the output register is busy.
        raddr = cur_q;
        if (out_free) begin
          out_load      = 1'b1;
          out_status_d  = STAT_OK;
          out_where_d   = POS_W'(idx_q);
          out_element_d = to_element(vrdata);
          out_count_d   = OCNT_W'(count_q);
          out_last_d    = ((idx_q + CNT_W'(1)) == count_q);
          if ((idx_q + CNT_W'(1)) == count_q) begin
            state_d = ST_IDLE;
          end else begin
            cur_d = slot_ok(lrdata);
            raddr = slot_ok(lrdata);
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_status_d  = st_q;
          out_where_d   = wh_q;
          out_element_d = '0;
          out_count_d   = OCNT_W'(count_q);
          out_last_d    = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= '0;
      final_q     <= '0;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      final_q     <= final_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    value_q       <= value_d;
    pos_q         <= pos_d;
    ep_q          <= ep_d;
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    dead_q        <= dead_d;
    rem_q         <= rem_d;
    idx_q         <= idx_d;
    st_q          <= st_d;
    wh_q          <= wh_d;
    out_status_q  <= out_status_d;
    out_where_q   <= out_where_d;
    out_element_q <= out_element_d;
    out_count_q   <= out_count_d;
    out_last_q    <= out_last_d;
  end

endmodule
